// File: rtl/core/ipv4rt_pkg.sv
// Shared types, codes and defaults for the IPv4 route table lookup.
`timescale 1ns / 1ps
`default_nettype none

package ipv4rt_pkg;

    // Defaults for top level parameters
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int IFACE_BITS_DEF    = 8;

    // Fixed field widths of the request and result
    localparam int SLOT_FIELD_W  = 5;
    localparam int IP_W          = 32;
    localparam int IFACE_FIELD_W = 8;

    // Request kind carried in tuser
    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    // Route status codes
    typedef enum logic [1:0] {
        RS_NONE     = 2'd0,
        RS_SPECIFIC = 2'd1,
        RS_DEFAULT  = 2'd2
    } rstat_t;

    // Controller to datapath commands
    typedef struct packed {
        logic entry_wr;      // store the slot of an accepted write request
        logic start_lookup;  // latch target and restart the scan
        logic clear_wr;      // clear one slot during the reset sweep
        logic issue_read;    // read the next slot
        logic eval;          // evaluate the slot read in the previous cycle
        logic load_out;      // move the lookup result to the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic addr_last;     // sweep address is at the last slot
        logic issue_done;    // every slot has been read for this lookup
        logic scan_done;     // lookup result is decided this cycle
        logic out_free;      // output register can take a new result
    } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ipv4rt_ctrl.sv
// Controller state machine: clear sweep, request intake, table scan, result handoff.
`timescale 1ns / 1ps
`default_nettype none

module ipv4rt_ctrl
    import ipv4rt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    input  wire op_t     s_op,
    input  wire dp_sts_t sts,
    output logic         s_ready,
    output dp_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLEAR = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode state into commands and the next state
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_LOOKUP) begin
                        cmd.start_lookup = 1'b1;
                        state_next       = ST_SCAN;
                    end else begin
                        cmd.entry_wr = 1'b1;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.issue_read = !sts.issue_done;
                cmd.eval       = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Start with the clear sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ipv4rt_datapath.sv
// Datapath: route table memory, scan pipeline, match logic and output register.
`timescale 1ns / 1ps
`default_nettype none

module ipv4rt_datapath
    import ipv4rt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IFACE_BITS    = IFACE_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire dp_cmd_t                  cmd,
    output dp_sts_t                       sts,
    input  wire logic [SLOT_FIELD_W-1:0]  in_index,
    input  wire logic [IP_W-1:0]          in_dest,
    input  wire logic [IP_W-1:0]          in_mask,
    input  wire logic [IP_W-1:0]          in_gateway,
    input  wire logic [IFACE_FIELD_W-1:0] in_iface,
    input  wire logic [IP_W-1:0]          in_target,
    input  wire logic                     m_ready,
    output logic                          m_valid,
    output logic [1:0]                    out_status,
    output logic [SLOT_FIELD_W-1:0]       out_index,
    output logic [IP_W-1:0]               out_gateway,
    output logic [IFACE_FIELD_W-1:0]      out_iface
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic                  valid;
        logic [IP_W-1:0]       dest;
        logic [IP_W-1:0]       mask;
        logic [IP_W-1:0]       gateway;
        logic [IFACE_BITS-1:0] iface;
    } entry_t;

    entry_t mem [TABLE_ENTRIES];

    entry_t                rd_data_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_live_reg;
    logic [IDX_W-1:0]      addr_reg;
    logic                  issue_done_reg;
    logic [IP_W-1:0]       target_reg;

    logic                  have_def_reg;
    logic [IDX_W-1:0]      def_idx_reg;
    logic [IP_W-1:0]       def_gw_reg;
    logic [IFACE_BITS-1:0] def_if_reg;

    rstat_t                res_status_reg;
    logic [IDX_W-1:0]      res_idx_reg;
    logic [IP_W-1:0]       res_gw_reg;
    logic [IFACE_BITS-1:0] res_if_reg;

    logic                  m_valid_reg;
    rstat_t                out_status_reg;
    logic [SLOT_FIELD_W-1:0]  out_index_reg;
    logic [IP_W-1:0]          out_gw_reg;
    logic [IFACE_FIELD_W-1:0] out_if_reg;

    logic                  idx_ok;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    entry_t                mem_wd;
    logic                  eval_fire;
    logic                  is_def_now;
    logic                  hit_now;
    logic                  scan_done;

    // Select write port source: clear sweep or table write request
    always_comb begin
        idx_ok = 32'(in_index) < 32'(TABLE_ENTRIES);
        mem_we = cmd.clear_wr || (cmd.entry_wr && idx_ok);
        mem_wa = cmd.clear_wr ? addr_reg : IDX_W'(in_index);
        mem_wd = '0;
        if (!cmd.clear_wr) begin
            mem_wd.valid   = 1'b1;
            mem_wd.dest    = in_dest;
            mem_wd.mask    = in_mask;
            mem_wd.gateway = in_gateway;
            mem_wd.iface   = IFACE_BITS'(in_iface);
        end
    end

    // Table memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.issue_read) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Classify the slot read in the previous cycle
    always_comb begin
        eval_fire  = cmd.eval && rd_live_reg;
        is_def_now = rd_data_reg.valid && !have_def_reg && (rd_data_reg.dest == '0);
        hit_now    = rd_data_reg.valid && !is_def_now
                     && ((target_reg & rd_data_reg.mask) == rd_data_reg.dest);
        scan_done  = rd_live_reg && (hit_now || (rd_idx_reg == LAST_IDX));
    end

    // Advance sweep and scan addresses
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_live_reg    <= 1'b0;
        end else if (cmd.start_lookup) begin
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_live_reg    <= 1'b0;
        end else begin
            if (cmd.issue_read || cmd.clear_wr) begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmd.issue_read) begin
                rd_live_reg <= 1'b1;
                if (addr_reg == LAST_IDX) begin
                    issue_done_reg <= 1'b1;
                end
            end
        end
    end

    // Track slot index of the read data and the lookup target
    always_ff @(posedge aclk) begin
        if (cmd.issue_read) begin
            rd_idx_reg <= addr_reg;
        end
        if (cmd.start_lookup) begin
            target_reg <= in_target;
        end
    end

    // Remember the default route once found
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_def_reg <= 1'b0;
        end else if (cmd.start_lookup) begin
            have_def_reg <= 1'b0;
        end else if (eval_fire && is_def_now) begin
            have_def_reg <= 1'b1;
        end
        if (eval_fire && is_def_now) begin
            def_idx_reg <= rd_idx_reg;
            def_gw_reg  <= rd_data_reg.gateway;
            def_if_reg  <= rd_data_reg.iface;
        end
    end

    // Decide the result when the scan ends
    always_ff @(posedge aclk) begin
        if (eval_fire && scan_done) begin
            if (hit_now) begin
                res_status_reg <= RS_SPECIFIC;
                res_idx_reg    <= rd_idx_reg;
                res_gw_reg     <= rd_data_reg.gateway;
                res_if_reg     <= rd_data_reg.iface;
            end else if (is_def_now) begin
                res_status_reg <= RS_DEFAULT;
                res_idx_reg    <= rd_idx_reg;
                res_gw_reg     <= rd_data_reg.gateway;
                res_if_reg     <= rd_data_reg.iface;
            end else if (have_def_reg) begin
                res_status_reg <= RS_DEFAULT;
                res_idx_reg    <= def_idx_reg;
                res_gw_reg     <= def_gw_reg;
                res_if_reg     <= def_if_reg;
            end else begin
                res_status_reg <= RS_NONE;
                res_idx_reg    <= '0;
                res_gw_reg     <= '0;
                res_if_reg     <= '0;
            end
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= SLOT_FIELD_W'(res_idx_reg);
            out_gw_reg     <= res_gw_reg;
            out_if_reg     <= IFACE_FIELD_W'(res_if_reg);
        end
    end

    // Report status to the controller
    always_comb begin
        sts.addr_last  = addr_reg == LAST_IDX;
        sts.issue_done = issue_done_reg;
        sts.scan_done  = scan_done;
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid     = m_valid_reg;
    assign out_status  = out_status_reg;
    assign out_index   = out_index_reg;
    assign out_gateway = out_gw_reg;
    assign out_iface   = out_if_reg;

endmodule

`default_nettype wire

// File: rtl/core/ipv4_route_first_match_lookup_top.sv
// Top level of the IPv4 first-match route table lookup.
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tuser: kind, tdata: slot fields, target
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: status, slot, gateway, iface
//
// Write requests can be taken back to back. A lookup request reads one slot per
// cycle through the single read port of the table memory and stops at the first
// match other than the default route; the next request is taken only after its
// result reaches the output register. After reset a sweep clears the valid bits,
// one slot per cycle, with s_axis_tready low. A result waits in the output
// register while the next request is taken; a lookup that finishes while the
// previous result is still held waits for it to be taken.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_route_first_match_lookup_top
    import ipv4rt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IFACE_BITS    = IFACE_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [4:0] entry_index, [36:5] entry_dest, [68:37] entry_mask,
    // [100:69] entry_gateway, [108:101] entry_iface, [140:109] target_addr, [143:141] zero
    input  wire logic [143:0] s_axis_tdata,
    // [0] operation
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [1:0] route_status, [6:2] route_index, [38:7] route_gateway,
    // [46:39] route_iface, [47] zero
    output logic [47:0]       m_axis_tdata
);

    dp_cmd_t                  cmd;
    dp_sts_t                  sts;
    op_t                      s_op;
    logic [1:0]               out_status;
    logic [SLOT_FIELD_W-1:0]  out_index;
    logic [IP_W-1:0]          out_gateway;
    logic [IFACE_FIELD_W-1:0] out_iface;

    assign s_op = op_t'(s_axis_tuser);

    ipv4rt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_op    (s_op),
        .sts     (sts),
        .s_ready (s_axis_tready),
        .cmd     (cmd)
    );

    ipv4rt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IFACE_BITS    (IFACE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_index    (s_axis_tdata[4:0]),
        .in_dest     (s_axis_tdata[36:5]),
        .in_mask     (s_axis_tdata[68:37]),
        .in_gateway  (s_axis_tdata[100:69]),
        .in_iface    (s_axis_tdata[108:101]),
        .in_target   (s_axis_tdata[140:109]),
        .m_ready     (m_axis_tready),
        .m_valid     (m_axis_tvalid),
        .out_status  (out_status),
        .out_index   (out_index),
        .out_gateway (out_gateway),
        .out_iface   (out_iface)
    );

    // Pack the result
    assign m_axis_tdata = {1'b0, out_iface, out_gateway, out_index, out_status};

    // No request is taken during the clear sweep
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_wr |-> !s_axis_tready)
        else $error("request ready during clear sweep");

    // A result is only loaded when the output register is free
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending result");

    // A lookup request blocks intake in the following cycle
    a_lookup_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && (s_op == OP_LOOKUP)) |=> !s_axis_tready)
        else $error("request taken while a lookup scan is running");

    // A loaded result appears on the output in the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: sim/route_lookup_checker.sv
// Checker for the IPv4 route table: predicts every lookup result and compares it.
`timescale 1ns / 1ps

module route_lookup_checker
    import ipv4rt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IFACE_BITS    = IFACE_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    // [4:0] entry_index, [36:5] entry_dest, [68:37] entry_mask,
    // [100:69] entry_gateway, [108:101] entry_iface, [140:109] target_addr, [143:141] zero
    input  wire logic [143:0] s_axis_tdata,
    // [0] operation
    input  wire logic [0:0]   s_axis_tuser,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [1:0] route_status, [6:2] route_index, [38:7] route_gateway,
    // [46:39] route_iface, [47] zero
    input  wire logic [47:0]  m_axis_tdata,
    output int                error_count,
    output int                pending_lookups
);

    localparam int IFACE_KEEP = (1 << IFACE_BITS) - 1;

    typedef struct packed {
        rstat_t                   status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [IP_W-1:0]          gateway;
        logic [IFACE_FIELD_W-1:0] iface;
    } route_t;

    // Shadow copy of the route table
    logic                     route_valid   [TABLE_ENTRIES];
    logic [IP_W-1:0]          route_dest    [TABLE_ENTRIES];
    logic [IP_W-1:0]          route_mask    [TABLE_ENTRIES];
    logic [IP_W-1:0]          route_gateway [TABLE_ENTRIES];
    logic [IFACE_FIELD_W-1:0] route_iface   [TABLE_ENTRIES];

    route_t expected_routes [$];

    // Pick the lowest matching slot other than the default, else the default, else none
    function automatic route_t first_match_route(input logic [IP_W-1:0] target);
        route_t r;
        int     dflt;
        int     hit;
        int     i;
        dflt = -1;
        hit  = -1;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (dflt < 0 && route_valid[i] && route_dest[i] == '0)
                dflt = i;
        end
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && route_valid[i] && i != dflt
                    && (target & route_mask[i]) == route_dest[i])
                hit = i;
        end
        r = '0;
        r.status = RS_NONE;
        if (hit >= 0) begin
            r.status = RS_SPECIFIC;
        end else if (dflt >= 0) begin
            r.status = RS_DEFAULT;
            hit = dflt;
        end
        if (r.status != RS_NONE) begin
            r.slot    = SLOT_FIELD_W'(hit);
            r.gateway = route_gateway[hit];
            r.iface   = route_iface[hit];
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        route_t                   want;
        route_t                   got;
        logic [SLOT_FIELD_W-1:0]  idx;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                route_valid[i] = 1'b0;
            expected_routes.delete();
        end else begin
            // Compare a taken result with the oldest pending lookup
            if (m_axis_tvalid && m_axis_tready) begin
                got.status  = rstat_t'(m_axis_tdata[1:0]);
                got.slot    = m_axis_tdata[6:2];
                got.gateway = m_axis_tdata[38:7];
                got.iface   = m_axis_tdata[46:39];
                if (expected_routes.size() == 0) begin
                    error_count++;
                    $error("result with no lookup pending: tdata %h", m_axis_tdata);
                end else begin
                    want = expected_routes.pop_front();
                    if (got.status != want.status) begin
                        error_count++;
                        $error("route_status: expected %0d, actual %0d",
                               want.status, got.status);
                    end
                    if (got.slot != want.slot) begin
                        error_count++;
                        $error("route_index: expected %0d, actual %0d",
                               want.slot, got.slot);
                    end
                    if (got.gateway != want.gateway) begin
                        error_count++;
                        $error("route_gateway: expected %h, actual %h",
                               want.gateway, got.gateway);
                    end
                    if (got.iface != want.iface) begin
                        error_count++;
                        $error("route_iface: expected %h, actual %h",
                               want.iface, got.iface);
                    end
                end
            end
            // Apply an accepted request: store a slot or predict a lookup
            if (s_axis_tvalid && s_axis_tready) begin
                if (op_t'(s_axis_tuser[0]) == OP_WRITE) begin
                    idx = s_axis_tdata[4:0];
                    if (int'(idx) < TABLE_ENTRIES) begin
                        route_valid[idx]   = 1'b1;
                        route_dest[idx]    = s_axis_tdata[36:5];
                        route_mask[idx]    = s_axis_tdata[68:37];
                        route_gateway[idx] = s_axis_tdata[100:69];
                        route_iface[idx]   = IFACE_FIELD_W'(s_axis_tdata[108:101] & IFACE_KEEP);
                    end
                end else begin
                    expected_routes.insert(expected_routes.size(),
                                           first_match_route(s_axis_tdata[140:109]));
                end
            end
        end
        pending_lookups = expected_routes.size();
    end

endmodule

// File: sim/ipv4_route_first_match_lookup_top_tb.sv
// Testbench top for the IPv4 route table lookup: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module ipv4_route_first_match_lookup_top_tb;
    import ipv4rt_pkg::*;

    localparam int RANDOM_REQUESTS  = 1500;
    localparam int STUCK_LIMIT      = 2000;
    localparam int LONG_HOLD_AT     = 200;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PAUSE_AT         = 900;
    localparam int TAIL_CYCLES      = TABLE_ENTRIES_DEF + 8;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [4:0] entry_index, [36:5] entry_dest, [68:37] entry_mask,
    // [100:69] entry_gateway, [108:101] entry_iface, [140:109] target_addr, [143:141] zero
    logic [143:0] s_axis_tdata;
    // [0] operation
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [1:0] route_status, [6:2] route_index, [38:7] route_gateway,
    // [46:39] route_iface, [47] zero
    logic [47:0]  m_axis_tdata;

    int error_count;
    int pending_lookups;

    // Sender pacing; hold_off is shared with the result sink
    bit hold_off;
    int tx_max;
    int sent;

    // Table contents as written, used to aim lookups at real routes
    logic [IP_W-1:0] aim_dest [TABLE_ENTRIES_DEF];
    logic [IP_W-1:0] aim_mask [TABLE_ENTRIES_DEF];
    bit              aim_set  [TABLE_ENTRIES_DEF];

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    ipv4_route_first_match_lookup_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    route_lookup_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .error_count     (error_count),
        .pending_lookups (pending_lookups)
    );

    // Offer one request after a random gap, none during a hold-off, and hold it until it is taken
    task automatic send_request(input op_t op, input logic [4:0] idx,
                                input logic [31:0] dest, input logic [31:0] mask,
                                input logic [31:0] gw, input logic [7:0] iface,
                                input logic [31:0] target);
        int gap;
        if (sent % 64 == 0)
            tx_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
        gap = hold_off ? 0 : $urandom_range(0, tx_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, target, iface, gw, mask, dest, idx};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sent++;
    endtask

    // Write one slot; the target field carries noise
    task automatic write_route(input logic [4:0] idx, input logic [31:0] dest,
                               input logic [31:0] mask, input logic [31:0] gw,
                               input logic [7:0] iface);
        aim_dest[idx] = dest;
        aim_mask[idx] = mask;
        aim_set[idx]  = 1'b1;
        send_request(OP_WRITE, idx, dest, mask, gw, iface, $urandom);
    endtask

    // Look up one address; the slot fields carry noise
    task automatic lookup_route(input logic [31:0] target);
        send_request(OP_LOOKUP, 5'($urandom), $urandom, $urandom, $urandom,
                     8'($urandom), target);
    endtask

    // Take results after random stalls, with one long hold-off
    initial begin : result_sink
        int stall;
        int taken;
        int rx_max;
        taken  = 0;
        rx_max = 9;
        hold_off = 1'b0;
        m_axis_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken % 64 == 0)
                rx_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            stall = $urandom_range(0, rx_max);
            if (taken == LONG_HOLD_AT) begin
                hold_off = 1'b1;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            hold_off = 1'b0;
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // End the run when nothing moves on either channel for too long
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int              n;
        int              plen;
        int              j;
        logic [4:0]      idx;
        logic [IP_W-1:0] dest;
        logic [IP_W-1:0] mask;
        logic [IP_W-1:0] target;
        sent   = 0;
        tx_max = 9;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            aim_set[i] = 1'b0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_WRITE;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table: no route at either address extreme
        lookup_route(32'h0000_0000);
        lookup_route(32'hFFFF_FFFF);
        // Host route at the top slot with all-ones fields
        write_route(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        lookup_route(32'hFFFF_FFFF);
        lookup_route(32'hFFFF_FFFE);
        // Default route, then a specific network below it
        write_route(5'd5, 32'h0, 32'h0, 32'hC0A8_0001, 8'h01);
        lookup_route(32'h0A00_0001);
        write_route(5'd0, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 8'h00);
        lookup_route(32'h0A0A_0A0A);
        // Zero destination that is not the default acts as an ordinary route
        write_route(5'd9, 32'h0, 32'hFFFF_FF00, 32'h1234_5678, 8'h5A);
        lookup_route(32'h0000_00FF);
        lookup_route(32'h0B00_0000);
        // Lower zero destination takes over the default; old default matches all
        write_route(5'd2, 32'h0, 32'h0, 32'h8765_4321, 8'h80);
        lookup_route(32'hDEAD_BEEF);
        // Rewrite a slot with new values
        write_route(5'd5, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0102_0304, 8'hA5);
        lookup_route(32'hC0A8_1234);
        lookup_route(32'hDEAD_BEEF);
        // Destination with bits outside its mask can never match
        write_route(5'd0, 32'h0A00_00FF, 32'hFF00_0000, 32'h5555_AAAA, 8'h33);
        lookup_route(32'h0A00_00FF);
        lookup_route(32'h0000_0000);

        // Random mix: mostly prefix routes and lookups aimed at them
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == PAUSE_AT) begin
                // Let the checker record the last request before waiting on it
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                wait (pending_lookups == 0);
            end
            if ($urandom_range(0, 9) < 3) begin
                idx  = 5'($urandom);
                plen = $urandom_range(0, 32);
                mask = (plen == 0) ? 32'h0 : ~32'h0 << (32 - plen);
                case ($urandom_range(0, 19))
                    0: begin
                        dest = 32'h0;
                        mask = $urandom;
                    end
                    1, 2: begin
                        dest = $urandom;
                    end
                    default: begin
                        dest = $urandom & mask;
                    end
                endcase
                write_route(idx, dest, mask, $urandom, 8'($urandom));
            end else begin
                j = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
                case ($urandom_range(0, 19))
                    0: target = 32'h0;
                    1: target = 32'hFFFF_FFFF;
                    2: target = 32'h1 << $urandom_range(0, 31);
                    3, 4, 5, 6, 7: target = $urandom;
                    default: begin
                        if (aim_set[j])
                            target = (aim_dest[j] & aim_mask[j]) | ($urandom & ~aim_mask[j]);
                        else
                            target = $urandom;
                    end
                endcase
                lookup_route(target);
            end
        end

        // Drain the results, then let the block settle
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_lookups == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_lookups == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
